/* sv/gms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_pkg
// shared types and constants for the maze path search block
// ----------------------------------------------------------------------------
package gms_pkg;

  localparam int MAP_BITS = 16;
  localparam int MAX_OUT  = 16;
  localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COPY,
    ST_POP,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DIR_UP,
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_DONE
  } dir_t;

  typedef struct packed {
    logic in_grid;
    logic free;
  } nbr_stat_t;

endpackage

/* sv/gms_nbr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_nbr
// neighbor unit: steps from the walk top in one direction and checks
// the grid edge, the obstacle map and the visited set
// ----------------------------------------------------------------------------
module gms_nbr #(
  parameter int ROWS = 4,
  parameter int COLS = 4,
  localparam int CELLS = ROWS * COLS,
  localparam int RW = $clog2(ROWS),
  localparam int CLW = $clog2(COLS),
  localparam int CW = $clog2(CELLS)
) (
  input  logic [gms_pkg::MAP_BITS-1:0] map,
  input  logic [CELLS-1:0]             visited,
  input  logic [RW-1:0]                row,
  input  logic [CLW-1:0]               col,
  input  logic [CW-1:0]                cur_cell,
  input  gms_pkg::dir_t                dir,
  output logic [RW-1:0]                nrow,
  output logic [CLW-1:0]               ncol,
  output logic [CW-1:0]                ncell,
  output gms_pkg::nbr_stat_t           stat
);

  logic [CELLS-1:0] blk;

  // cells past the map bits are open
  for (genvar i = 0; i < CELLS; i++) begin : g_blk
    if (i < gms_pkg::MAP_BITS) begin : g_map
      assign blk[i] = map[i];
    end else begin : g_open
      assign blk[i] = 1'b0;
    end
  end

  always_comb begin
    nrow = row;
    ncol = col;
    ncell = cur_cell;
    stat.in_grid = 1'b0;
    case (dir)
      gms_pkg::DIR_UP: begin
        stat.in_grid = (row != '0);
        nrow = row - RW'(1);
        ncell = cur_cell - CW'(COLS);
      end
      gms_pkg::DIR_RIGHT: begin
        stat.in_grid = (col != CLW'(COLS - 1));
        ncol = col + CLW'(1);
        ncell = cur_cell + CW'(1);
      end
      gms_pkg::DIR_DOWN: begin
        stat.in_grid = (row != RW'(ROWS - 1));
        nrow = row + RW'(1);
        ncell = cur_cell + CW'(COLS);
      end
      gms_pkg::DIR_LEFT: begin
        stat.in_grid = (col != '0);
        ncol = col - CLW'(1);
        ncell = cur_cell - CW'(1);
      end
      default: begin
        stat.in_grid = 1'b0;
      end
    endcase
    stat.free = stat.in_grid && !blk[ncell] && !visited[ncell];
  end

endmodule

/* sv/grid_maze_shortest_path_dfs.sv */
`timescale 1ns / 1ps
// search: each direction is tried in turn, a backtrack goes through the pop state, and
//   the stack is copied out each time a shorter path is recorded
// throughput: one maze at a time, set by the single stack port and neighbor unit
// results: one beat per path cell (or one beat if none)
// reset: synchronous, returns to idle with an empty stack; stack and path
//   stores are not cleared
// ----------------------------------------------------------------------------
// grid_maze_shortest_path_dfs
// backtracking depth-first walk over all simple paths from top-left to
// bottom-right, counting them and keeping the first shortest one
// ----------------------------------------------------------------------------
module grid_maze_shortest_path_dfs #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] blocked_map,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [2:0]  cell_row,
  output logic [2:0]  cell_col,
  output logic [3:0]  step_index,
  output logic [4:0]  path_length,
  output logic [15:0] path_total,
  output logic        last
);

  localparam int CELLS = ROWS * COLS;
  localparam int RW = $clog2(ROWS);
  localparam int CLW = $clog2(COLS);
  localparam int CW = $clog2(CELLS);
  localparam int SPW = $clog2(CELLS + 1);
  localparam int EW = CW + RW + CLW + 3;

  gms_pkg::state_t state, state_next;

  logic [15:0]      map;
  logic [CW-1:0]    top_cell;
  logic [RW-1:0]    top_row;
  logic [CLW-1:0]   top_col;
  gms_pkg::dir_t    top_dir;
  logic [SPW-1:0]   sp;
  logic [CELLS-1:0] visited;
  logic [SPW-1:0]   best_len;
  logic [15:0]      total;
  logic [4:0]       cp_idx;
  logic             cp_wr_vld;
  logic [3:0]       cp_wr_idx;
  logic [3:0]       emit_idx;

  logic [EW-1:0]    stk_mem [CELLS];
  logic [EW-1:0]    rd_data;
  logic [RW-1:0]    best_row [gms_pkg::MAX_OUT];
  logic [CLW-1:0]   best_col [gms_pkg::MAX_OUT];

  logic [RW-1:0]      nb_row;
  logic [CLW-1:0]     nb_col;
  logic [CW-1:0]      nb_cell;
  gms_pkg::nbr_stat_t nb_stat;

  logic [SPW-1:0] sp_m1;
  logic [4:0]     ncopy;
  logic [4:0]     nemit;
  logic           at_exit;
  logic           better;
  logic           copy_done;
  logic           push;
  logic           pop;
  logic [CW-1:0]  rd_addr;
  gms_pkg::dir_t  dir_inc;

  gms_nbr #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_nbr (
    .map      (map),
    .visited  (visited),
    .row      (top_row),
    .col      (top_col),
    .cur_cell (top_cell),
    .dir      (top_dir),
    .nrow     (nb_row),
    .ncol     (nb_col),
    .ncell    (nb_cell),
    .stat     (nb_stat)
  );

  assign sp_m1 = sp - SPW'(1);
  assign ncopy = (int'(sp_m1) >= gms_pkg::MAX_OUT) ? 5'(gms_pkg::MAX_OUT) : 5'(sp_m1);
  assign nemit = (int'(best_len) >= gms_pkg::MAX_OUT) ? 5'(gms_pkg::MAX_OUT)
                                                      : 5'(best_len);
  assign at_exit = (top_cell == CW'(CELLS - 1));
  assign better = (best_len == '0) || (sp < best_len);
  assign copy_done = (cp_idx == ncopy);
  assign dir_inc = gms_pkg::dir_t'(top_dir + 3'd1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gms_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = blocked_map[0] ? gms_pkg::ST_EMIT : gms_pkg::ST_SEARCH;
        end
      end
      gms_pkg::ST_SEARCH: begin
        if (at_exit && better) begin
          state_next = gms_pkg::ST_COPY;
        end else if (at_exit || top_dir == gms_pkg::DIR_DONE) begin
          state_next = (sp == SPW'(1)) ? gms_pkg::ST_EMIT : gms_pkg::ST_POP;
        end
      end
      gms_pkg::ST_COPY: begin
        if (copy_done) begin
          state_next = (sp == SPW'(1)) ? gms_pkg::ST_EMIT : gms_pkg::ST_POP;
        end
      end
      gms_pkg::ST_POP: begin
        state_next = gms_pkg::ST_SEARCH;
      end
      gms_pkg::ST_EMIT: begin
        if (out_ready && last) begin
          state_next = gms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gms_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state == gms_pkg::ST_IDLE);
    out_valid = (state == gms_pkg::ST_EMIT);
    push = 1'b0;
    pop = 1'b0;
    rd_addr = CW'(sp - SPW'(2));
    case (state)
      gms_pkg::ST_SEARCH: begin
        pop = (at_exit && !better) || (!at_exit && top_dir == gms_pkg::DIR_DONE);
        push = !at_exit && top_dir != gms_pkg::DIR_DONE && nb_stat.free
               && (sp < SPW'(CELLS));
      end
      gms_pkg::ST_COPY: begin
        pop = copy_done;
        if (!copy_done) begin
          rd_addr = CW'(cp_idx);
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // walk stack below the top entry
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[CW'(sp_m1)] <= {top_cell, top_row, top_col, 3'(dir_inc)};
    end
    rd_data <= stk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gms_pkg::ST_IDLE;
      sp <= '0;
      visited <= '0;
      cp_wr_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (cp_wr_vld) begin
        best_row[cp_wr_idx] <= rd_data[3 + CLW +: RW];
        best_col[cp_wr_idx] <= rd_data[3 +: CLW];
      end
      if (pop) begin
        visited[top_cell] <= 1'b0;
        sp <= sp_m1;
      end
      case (state)
        gms_pkg::ST_IDLE: begin
          if (in_valid) begin
            map <= blocked_map;
            total <= '0;
            best_len <= '0;
            emit_idx <= '0;
            top_cell <= '0;
            top_row <= '0;
            top_col <= '0;
            top_dir <= gms_pkg::DIR_UP;
            sp <= SPW'(!blocked_map[0]);
            visited <= CELLS'(!blocked_map[0]);
          end
        end
        gms_pkg::ST_SEARCH: begin
          if (at_exit) begin
            if (total != gms_pkg::TOTAL_MAX) begin
              total <= total + 16'd1;
            end
            if (better) begin
              best_len <= sp;
              cp_idx <= '0;
              if (int'(sp_m1) < gms_pkg::MAX_OUT) begin
                best_row[4'(sp_m1)] <= top_row;
                best_col[4'(sp_m1)] <= top_col;
              end
            end
          end else if (top_dir != gms_pkg::DIR_DONE) begin
            top_dir <= dir_inc;
            if (push) begin
              top_cell <= nb_cell;
              top_row <= nb_row;
              top_col <= nb_col;
              top_dir <= gms_pkg::DIR_UP;
              sp <= sp + SPW'(1);
              visited[nb_cell] <= 1'b1;
            end
          end
        end
        gms_pkg::ST_COPY: begin
          cp_wr_vld <= !copy_done;
          if (!copy_done) begin
            cp_idx <= cp_idx + 5'd1;
            cp_wr_idx <= 4'(cp_idx);
          end
        end
        gms_pkg::ST_POP: begin
          top_cell <= rd_data[RW + CLW + 3 +: CW];
          top_row <= rd_data[3 + CLW +: RW];
          top_col <= rd_data[3 +: CLW];
          top_dir <= gms_pkg::dir_t'(rd_data[2:0]);
        end
        gms_pkg::ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 4'd1;
          end
        end
        default: begin
          cp_wr_vld <= 1'b0;
        end
      endcase
    end
  end

  // result beat
  always_comb begin
    found = (best_len != '0);
    cell_row = found ? 3'(best_row[emit_idx]) + 3'd1 : 3'd0;
    cell_col = found ? 3'(best_col[emit_idx]) + 3'd1 : 3'd0;
    step_index = found ? emit_idx : 4'd0;
    path_length = 5'(best_len);
    path_total = total;
    last = !found || ({1'b0, emit_idx} + 5'd1 == nemit);
  end

  // stack depth tracks the visited set
  a_depth_visited: assert property (@(posedge clk) disable iff (rst)
    $countones(visited) == sp)
    else $error("stack depth and visited set disagree");

  a_top_visited: assert property (@(posedge clk) disable iff (rst)
    (state == gms_pkg::ST_SEARCH) |-> visited[top_cell])
    else $error("walk top not marked visited");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("block not idle after last beat");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> ({1'b0, emit_idx} < nemit))
    else $error("emit index past path end");

  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    (state == gms_pkg::ST_COPY) |-> (cp_idx <= ncopy) && at_exit)
    else $error("path copy out of range");

endmodule
